// ===== design/rsi_pkg.sv =====
package rsi_pkg;

  // Datapath widths, all exact for any 32 bit input pattern
  localparam int LW   = 33;        // origin minus center
  localparam int AW   = 64;        // a = D.D
  localparam int HW   = 66;        // h = D.L
  localparam int CW   = 67;        // c = L.L - r^2
  localparam int DW   = 132;       // discriminant magnitude
  localparam int RW   = 82;        // square root of disc * 2^32
  localparam int RMW  = RW + 2;    // square root remainder
  localparam int NW   = 85;        // root numerator, signed
  localparam int LAW  = 95;        // limit * a
  localparam int QW   = 31;        // quotient bits of a hit root
  localparam int CMPW = 96;        // compare width for the range test

  // Smallest floored root that counts as a hit (root must exceed 0.001)
  localparam int T_MIN = 66;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_CENTER_Z,
    CFG_RADIUS
  } cfg_idx_e;

  // Side data that travels with the discriminant through the square root
  typedef struct packed {
    logic                   ok;
    logic signed [HW-1:0]   h;
    logic [AW-1:0]          a;
    logic [LAW-1:0]         lim_a;
    logic signed [31:0]     limit;
  } rsi_side_t;

  // Side data that travels with the numerator through the divider
  typedef struct packed {
    logic               ok;
    logic signed [31:0] limit;
  } rsi_dside_t;

  // Front stages, square root, numerator, range test, divider, output
  localparam int LATENCY = 6 + RW + 2 + QW + 1;

endpackage

// ===== design/rsi_sqrt.sv =====
module rsi_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rsi_pkg::DW-1:0]      disc_i,
  input  rsi_pkg::rsi_side_t          side_i,
  output logic                        valid_o,
  output logic [rsi_pkg::RW-1:0]      root_o,
  output logic                        exact_o,
  output rsi_pkg::rsi_side_t          side_o
);

  localparam int RW  = rsi_pkg::RW;
  localparam int RMW = rsi_pkg::RMW;
  localparam int DW  = rsi_pkg::DW;

  logic                v_q    [RW];
  logic [DW-1:0]       x_q    [RW-1];
  logic [RMW-1:0]      rem_q  [RW];
  logic [RW-1:0]       root_q [RW];
  rsi_pkg::rsi_side_t  side_q [RW];

  // One root bit per stage, radicand is disc shifted up by 32
  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int K = RW - 1 - i;
    logic               v_in;
    logic [DW-1:0]      x_in;
    logic [RMW-1:0]     rem_in;
    logic [RW-1:0]      root_in;
    rsi_pkg::rsi_side_t side_in;
    logic [1:0]         pair;
    logic [RMW-1:0]     rem_sh;
    logic [RMW-1:0]     trial;
    logic               take;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = disc_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign x_in    = x_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    // Low 32 radicand bits are zero
    if (K >= 16) begin : g_pair
      assign pair = x_in[2*K-31:2*K-32];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_in[RMW-3:0], pair};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= take ? (rem_sh - trial) : rem_sh;
      root_q[i] <= {root_in[RW-2:0], take};
      side_q[i] <= side_in;
    end

    if (i < RW - 1) begin : g_keep_x
      always_ff @(posedge clk_i) begin
        x_q[i] <= x_in;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign exact_o = (rem_q[RW-1] == '0);
  assign side_o  = side_q[RW-1];

endmodule

// ===== design/rsi_div.sv =====
module rsi_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rsi_pkg::LAW-1:0]     num_i,
  input  logic [rsi_pkg::AW-1:0]      den_i,
  input  rsi_pkg::rsi_dside_t         side_i,
  output logic                        valid_o,
  output logic [rsi_pkg::QW-1:0]      quot_o,
  output rsi_pkg::rsi_dside_t         side_o
);

  localparam int QW  = rsi_pkg::QW;
  localparam int LAW = rsi_pkg::LAW;
  localparam int AW  = rsi_pkg::AW;

  logic                v_q    [QW];
  logic [LAW-1:0]      rem_q  [QW-1];
  logic [AW-1:0]       den_q  [QW-1];
  logic [QW-1:0]       quot_q [QW];
  rsi_pkg::rsi_dside_t side_q [QW];

  // Restoring division, one quotient bit per stage, top bit first
  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic                v_in;
    logic [LAW-1:0]      rem_in;
    logic [AW-1:0]       den_in;
    logic [QW-1:0]       quot_in;
    rsi_pkg::rsi_dside_t side_in;
    logic [LAW-1:0]      dsh;
    logic                take;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign quot_in = quot_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign dsh  = LAW'(den_in) << K;
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quot_q[i] <= {quot_in[QW-2:0], take};
      side_q[i] <= side_in;
    end

    if (i < QW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        rem_q[i] <= take ? (rem_in - dsh) : rem_in;
        den_q[i] <= den_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== design/ray_sphere_intersect.sv =====
// Ray against sphere test in signed Q16.16. One ray enters per clock (busy is
// always low) and its result leaves the end of the pipeline with done_o high
// for one cycle; the receiver cannot stall it. The pipeline is made up of the
// 82-stage square root of the discriminant and the 31-stage divider that forms
// the root, plus six front stages for the dot products and the discriminant
// and three stages around the divider. hit_o reports a root above 0.001 and
// below t_limit_i; t_out_o then holds that root, else t_limit_i unchanged.
// Write the sphere registers only while no ray is in flight.
module ray_sphere_intersect (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic signed [31:0]                origin_x_i,
  input  logic signed [31:0]                origin_y_i,
  input  logic signed [31:0]                origin_z_i,
  input  logic signed [31:0]                dir_x_i,
  input  logic signed [31:0]                dir_y_i,
  input  logic signed [31:0]                dir_z_i,
  input  logic signed [31:0]                t_limit_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic signed [31:0]                t_out_o
);

  localparam int LW   = rsi_pkg::LW;
  localparam int AW   = rsi_pkg::AW;
  localparam int HW   = rsi_pkg::HW;
  localparam int CW   = rsi_pkg::CW;
  localparam int DW   = rsi_pkg::DW;
  localparam int RW   = rsi_pkg::RW;
  localparam int NW   = rsi_pkg::NW;
  localparam int LAW  = rsi_pkg::LAW;
  localparam int QW   = rsi_pkg::QW;
  localparam int CMPW = rsi_pkg::CMPW;

  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [30:0]        radius_q;

  assign busy = 1'b0;

  // Sphere registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= 31'd65536;
    end else if (cfg_we_i) begin
      case (rsi_pkg::cfg_idx_e'(cfg_idx_i))
        rsi_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Z: center_z_q <= cfg_data_i;
        rsi_pkg::CFG_RADIUS:   radius_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] org  [3];
  logic signed [31:0] dir  [3];
  logic signed [31:0] cen  [3];

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;
  assign cen[0] = center_x_q;
  assign cen[1] = center_y_q;
  assign cen[2] = center_z_q;

  // Stage 1: L = O - center
  logic               s1_v_q;
  logic signed [LW-1:0] s1_l_q [3];
  logic signed [31:0] s1_d_q [3];
  logic signed [31:0] s1_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s1_l_q[k] <= LW'(org[k]) - LW'(cen[k]);
      s1_d_q[k] <= dir[k];
    end
    s1_lim_q <= t_limit_i;
  end

  // Stage 2: component products
  logic                  s2_v_q;
  logic signed [63:0]    s2_dd_q [3];
  logic signed [64:0]    s2_dl_q [3];
  logic signed [65:0]    s2_ll_q [3];
  logic [61:0]           s2_rr_q;
  logic signed [31:0]    s2_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s2_dd_q[k] <= s1_d_q[k] * s1_d_q[k];
      s2_dl_q[k] <= s1_d_q[k] * s1_l_q[k];
      s2_ll_q[k] <= s1_l_q[k] * s1_l_q[k];
    end
    s2_rr_q  <= radius_q * radius_q;
    s2_lim_q <= s1_lim_q;
  end

  // Stage 3: a, h, c
  logic                 s3_v_q;
  logic [AW-1:0]        s3_a_q;
  logic signed [HW-1:0] s3_h_q;
  logic signed [CW-1:0] s3_c_q;
  logic signed [31:0]   s3_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_a_q <= AW'(s2_dd_q[0][62:0]) + AW'(s2_dd_q[1][62:0]) + AW'(s2_dd_q[2][62:0]);
    s3_h_q <= HW'(s2_dl_q[0]) + HW'(s2_dl_q[1]) + HW'(s2_dl_q[2]);
    s3_c_q <= $signed(CW'(s2_ll_q[0][64:0])) + $signed(CW'(s2_ll_q[1][64:0]))
            + $signed(CW'(s2_ll_q[2][64:0])) - $signed(CW'(s2_rr_q));
    s3_lim_q <= s2_lim_q;
  end

  // Stage 4: partial products of h*h, a*|c| and limit*a
  logic [HW-1:0] hmag;
  logic [CW-1:0] cmag;

  assign hmag = s3_h_q[HW-1] ? HW'(-s3_h_q) : HW'(s3_h_q);
  assign cmag = s3_c_q[CW-1] ? CW'(-s3_c_q) : CW'(s3_c_q);

  logic                 s4_v_q;
  logic [65:0]          s4_hll_q, s4_hlh_q, s4_hhh_q;
  logic [65:0]          s4_all_q, s4_alh_q, s4_ahl_q, s4_ahh_q;
  logic [62:0]          s4_la0_q, s4_la1_q;
  logic                 s4_cneg_q;
  logic [AW-1:0]        s4_a_q;
  logic signed [HW-1:0] s4_h_q;
  logic signed [31:0]   s4_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_hll_q  <= hmag[32:0] * hmag[32:0];
    s4_hlh_q  <= hmag[32:0] * hmag[65:33];
    s4_hhh_q  <= hmag[65:33] * hmag[65:33];
    s4_all_q  <= s3_a_q[31:0] * cmag[32:0];
    s4_alh_q  <= s3_a_q[31:0] * cmag[65:33];
    s4_ahl_q  <= s3_a_q[63:32] * cmag[32:0];
    s4_ahh_q  <= s3_a_q[63:32] * cmag[65:33];
    s4_la0_q  <= s3_lim_q[30:0] * s3_a_q[31:0];
    s4_la1_q  <= s3_lim_q[30:0] * s3_a_q[63:32];
    s4_cneg_q <= s3_c_q[CW-1];
    s4_a_q    <= s3_a_q;
    s4_h_q    <= s3_h_q;
    s4_lim_q  <= s3_lim_q;
  end

  // Stage 5: gather partial products
  logic                 s5_v_q;
  logic [DW-1:0]        s5_hh_q, s5_ac_q;
  logic [LAW-1:0]       s5_lima_q;
  logic                 s5_cneg_q;
  logic [AW-1:0]        s5_a_q;
  logic signed [HW-1:0] s5_h_q;
  logic signed [31:0]   s5_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_hh_q   <= DW'(s4_hll_q) + (DW'(s4_hlh_q) << 34) + (DW'(s4_hhh_q) << 66);
    s5_ac_q   <= DW'(s4_all_q) + (DW'(s4_alh_q) << 33) + (DW'(s4_ahl_q) << 32)
               + (DW'(s4_ahh_q) << 65);
    s5_lima_q <= LAW'(s4_la0_q) + (LAW'(s4_la1_q) << 32);
    s5_cneg_q <= s4_cneg_q;
    s5_a_q    <= s4_a_q;
    s5_h_q    <= s4_h_q;
    s5_lim_q  <= s4_lim_q;
  end

  // Stage 6: discriminant h*h - a*c and early miss cases
  rsi_pkg::rsi_side_t s6_side_d;
  logic [DW-1:0]      s6_disc_d;

  always_comb begin
    s6_disc_d       = s5_cneg_q ? (s5_hh_q + s5_ac_q) : (s5_hh_q - s5_ac_q);
    s6_side_d.ok    = (s5_a_q != '0) && !s5_lim_q[31] && (s5_cneg_q || (s5_hh_q >= s5_ac_q));
    s6_side_d.h     = s5_h_q;
    s6_side_d.a     = s5_a_q;
    s6_side_d.lim_a = s5_lima_q;
    s6_side_d.limit = s5_lim_q;
  end

  logic               s6_v_q;
  logic [DW-1:0]      s6_disc_q;
  rsi_pkg::rsi_side_t s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_disc_q <= s6_disc_d;
    s6_side_q <= s6_side_d;
  end

  // Square root of disc * 2^32
  logic               sq_v;
  logic [RW-1:0]      sq_root;
  logic               sq_exact;
  rsi_pkg::rsi_side_t sq_side;

  rsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_v_q),
    .disc_i  (s6_disc_q),
    .side_i  (s6_side_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .exact_o (sq_exact),
    .side_o  (sq_side)
  );

  // Numerator: -h * 2^16 - ceil(sqrt)
  logic [RW-1:0]        sq_ceil;
  logic signed [NW-1:0] num_d;

  assign sq_ceil = sq_root + RW'(!sq_exact);
  assign num_d   = -(NW'(sq_side.h) <<< 16) - $signed(NW'(sq_ceil));

  logic                 s7_v_q;
  logic signed [NW-1:0] s7_num_q;
  rsi_pkg::rsi_side_t   s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else begin
      s7_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_num_q  <= num_d;
    s7_side_q <= sq_side;
  end

  // Range test: 66*a <= num < limit*a means 0.001 < root < limit
  logic [CMPW-1:0]     num_u;
  logic [CMPW-1:0]     thr;
  rsi_pkg::rsi_dside_t s8_side_d;

  assign num_u = CMPW'(s7_num_q[NW-2:0]);
  assign thr   = CMPW'(s7_side_q.a) * CMPW'(rsi_pkg::T_MIN);

  always_comb begin
    s8_side_d.ok    = s7_side_q.ok && !s7_num_q[NW-1] && (num_u >= thr)
                   && (num_u < CMPW'(s7_side_q.lim_a));
    s8_side_d.limit = s7_side_q.limit;
  end

  logic                s8_v_q;
  logic [LAW-1:0]      s8_num_q;
  logic [AW-1:0]       s8_a_q;
  rsi_pkg::rsi_dside_t s8_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_num_q  <= LAW'(s7_num_q[NW-2:0]);
    s8_a_q    <= s7_side_q.a;
    s8_side_q <= s8_side_d;
  end

  // Floored root = num / a, fits 31 bits on a hit
  logic                dv_v;
  logic [QW-1:0]       dv_quot;
  rsi_pkg::rsi_dside_t dv_side;

  rsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s8_v_q),
    .num_i   (s8_num_q),
    .den_i   (s8_a_q),
    .side_i  (s8_side_q),
    .valid_o (dv_v),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // Output register
  logic               done_q;
  logic               hit_q;
  logic signed [31:0] t_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= dv_side.ok;
    t_out_q <= dv_side.ok ? $signed({1'b0, dv_quot}) : dv_side.limit;
  end

  assign done_o  = done_q;
  assign hit_o   = hit_q;
  assign t_out_o = t_out_q;

endmodule

// ===== design/rsi_checker.sv =====
module rsi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] t_limit_i,
  input logic               done_o,
  input logic               hit_o,
  input logic signed [31:0] t_out_o
);

  localparam int LAT = rsi_pkg::LATENCY;

  // Every accepted transaction returns after the fixed latency
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("missing result after accepted transaction");

  // No result without a transaction that caused it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without transaction");

  // A hit lies at or above the threshold and strictly below the limit
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (t_out_o > 65) && (t_out_o < $past(t_limit_i, LAT)))
    else $error("hit root out of range");

  // A miss returns the limit untouched
  a_miss_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (t_out_o == $past(t_limit_i, LAT)))
    else $error("miss does not return limit");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .t_limit_i (t_limit_i),
  .done_o    (done_o),
  .hit_o     (hit_o),
  .t_out_o   (t_out_o)
);
